// ===== rtl/adri_pkg.sv =====
// Shared types and constants of the dead-reckoning integrator.
`timescale 1ns / 1ps
`default_nettype none

package adri_pkg;

  // Opcodes of an input transaction.
  localparam logic [1:0] OP_SAMPLE    = 2'd0;
  localparam logic [1:0] OP_RST_VEL   = 2'd1;
  localparam logic [1:0] OP_RST_DIST  = 2'd2;
  localparam logic [1:0] OP_RST_ALL   = 2'd3;

  // Configuration register indexes.
  localparam logic CFG_GRAVITY  = 1'b0;
  localparam logic CFG_DEADBAND = 1'b1;
  localparam int   CFG_W        = 16;

  // Reset values of the configuration registers.
  localparam logic signed [15:0] GRAVITY_RESET  = 16'sd0;
  localparam logic [11:0]        DEADBAND_RESET = 12'd41;

  // Depth of the command queue between the front and back parts.
  localparam int QUEUE_DEPTH = 2;

  // Saturation limits.
  localparam logic signed [16:0] SAMPLE_MAX = 17'sh0FFFF;
  localparam logic [19:0]        DELTA_MAX  = 20'hFFFFF;
  localparam logic signed [39:0] VEL_MAX    = 40'sh7F_FFFF_FFFF;
  localparam logic signed [39:0] VEL_MIN    = 40'sh80_0000_0000;
  localparam logic signed [47:0] DIST_MAX   = 48'sh7FFF_FFFF_FFFF;
  localparam logic signed [47:0] DIST_MIN   = 48'sh8000_0000_0000;

  // Classified command handed from the front part to the back part.
  typedef struct packed {
    logic [1:0]         opcode;
    logic signed [16:0] sample;
    logic [19:0]        delta;
  } cmd_t;

endpackage

`default_nettype wire

// ===== rtl/adri_if.sv =====
// Channel interfaces for input items and results.
`timescale 1ns / 1ps
`default_nettype none

interface adri_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic signed [15:0] accel_raw;
  logic [31:0]        time_stamp;

  modport source (output valid, opcode, accel_raw, time_stamp, input ready);
  modport sink (input valid, opcode, accel_raw, time_stamp, output ready);
endinterface

interface adri_out_if;
  logic               valid;
  logic               ready;
  logic signed [16:0] smoothed_accel;
  logic signed [39:0] velocity;
  logic signed [47:0] distance;
  logic               saturated;

  modport source (output valid, smoothed_accel, velocity, distance, saturated, input ready);
  modport sink (input valid, smoothed_accel, velocity, distance, saturated, output ready);
endinterface

`default_nettype wire

// ===== rtl/adri_front.sv =====
// Front part: accepts transactions, conditions the sample and measures the time step.
`timescale 1ns / 1ps
`default_nettype none

module adri_front import adri_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  adri_in_if.sink                 items,
  input  wire logic signed [15:0] gravity_offset,
  input  wire logic               q_full,
  output logic                    q_push,
  output cmd_t                    q_data
);

  logic [31:0]        previous_time;
  logic signed [17:0] sample_wide;
  logic [31:0]        delta_wide;

  // A transaction is taken whenever the queue has room.
  assign items.ready = !q_full;
  assign q_push      = items.valid && !q_full;

  // Negate, remove the gravity offset and clip to the 17 bit range.
  // Only the upper limit can be crossed.
  assign sample_wide = -{{2{items.accel_raw[15]}}, items.accel_raw}
                       - {{2{gravity_offset[15]}}, gravity_offset};

  // Wrapped time step, clipped to DELTA_MAX.
  assign delta_wide = items.time_stamp - previous_time;

  always_comb begin
    q_data.opcode = items.opcode;
    if (sample_wide > 18'(SAMPLE_MAX)) begin
      q_data.sample = SAMPLE_MAX;
    end else begin
      q_data.sample = sample_wide[16:0];
    end
    if (|delta_wide[31:20]) begin
      q_data.delta = DELTA_MAX;
    end else begin
      q_data.delta = delta_wide[19:0];
    end
  end

  // Every opcode re-bases the time reference.
  always_ff @(posedge clk) begin
    if (rst) begin
      previous_time <= '0;
    end else if (q_push) begin
      previous_time <= items.time_stamp;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/adri_queue.sv =====
// Short command queue between the front and back parts.
`timescale 1ns / 1ps
`default_nettype none

module adri_queue import adri_pkg::*; (
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire cmd_t push_data,
  output logic      full,
  input  wire logic pop,
  output cmd_t      pop_data,
  output logic      empty
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  cmd_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_W'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = entries[rd_ptr];

  // Storage needs no reset.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/adri_back.sv =====
// Back part: rings, averaging, integration and the result register.
`timescale 1ns / 1ps
`default_nettype none

module adri_back import adri_pkg::*; #(
  parameter int RING_DEPTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic [11:0] deadband,
  input  wire logic        q_empty,
  input  wire cmd_t        q_data,
  output logic             q_pop,
  adri_out_if.source       results
);

  localparam int LOG_D  = $clog2(RING_DEPTH);
  localparam int SLOT_W = LOG_D;
  localparam int SUM_W  = 17 + LOG_D;
  localparam int MAG_W  = SUM_W;
  localparam int DIV_S  = MAG_W + LOG_D;
  localparam int K_W    = MAG_W + 2;
  localparam int PROD_W = MAG_W + K_W;
  localparam int HALF   = RING_DEPTH / 2;
  // Reciprocal of the ring depth, exact for every magnitude below 2^MAG_W.
  localparam logic [K_W-1:0] DIV_K =
    K_W'(((64'd1 << DIV_S) + RING_DEPTH - 1) / RING_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE, S_SUM, S_DIV, S_AVG, S_VMUL, S_VACC, S_DLO, S_DHI, S_DACC, S_EMIT
  } state_t;

  state_t state;

  // Ring memories and their valid bits.
  logic signed [16:0] sample_mem [RING_DEPTH];
  logic [19:0]        delta_mem  [RING_DEPTH];
  logic [RING_DEPTH-1:0] ring_vld;
  logic signed [16:0] rd_sample;
  logic [19:0]        rd_delta;
  logic               vld_old;
  logic               vld_central;

  logic [SLOT_W-1:0]  write_slot;
  logic [SLOT_W-1:0]  central;
  logic signed [SUM_W-1:0] sample_sum;
  logic signed [SUM_W-1:0] sum_next;
  logic signed [SUM_W-1:0] old_sample;

  cmd_t               cmd;
  logic [19:0]        dt;
  logic [MAG_W-1:0]   mag;
  logic               neg;
  logic [PROD_W-1:0]  prod_q;
  logic [16:0]        quot;
  logic signed [17:0] avg;
  logic signed [38:0] prod_v;
  logic signed [38:0] prod_v_rnd;
  logic signed [38:0] vstep;
  logic signed [40:0] vsum;
  logic [39:0]        p_lo;
  logic [39:0]        lo_rnd;
  logic signed [40:0] p_hi;
  logic signed [48:0] dsum;
  logic signed [39:0] velocity_acc;
  logic signed [47:0] distance_acc;
  logic               hit;
  logic               mem_we;

  // Result register.
  logic               out_valid;
  logic signed [16:0] out_avg;
  logic signed [39:0] out_vel;
  logic signed [47:0] out_dist;
  logic               out_sat;
  logic [16:0]        out_mag;

  assign q_pop  = (state == S_IDLE) && !q_empty;
  assign mem_we = q_pop && (q_data.opcode == OP_SAMPLE);

  // Slot of the central delta, half a ring behind the write slot.
  assign central = (write_slot >= SLOT_W'(HALF)) ? write_slot - SLOT_W'(HALF)
                                                 : write_slot + SLOT_W'(RING_DEPTH - HALF);

  // Running sum after this command.
  assign old_sample = vld_old ? SUM_W'(rd_sample) : '0;
  always_comb begin
    case (cmd.opcode)
      OP_SAMPLE:  sum_next = sample_sum + SUM_W'(cmd.sample) - old_sample;
      OP_RST_ALL: sum_next = '0;
      default:    sum_next = sample_sum;
    endcase
  end

  // Quotient magnitude, rounding of the two integration steps.
  assign quot       = prod_q[DIV_S +: 17];
  assign prod_v_rnd = prod_v + 39'sd1024;
  assign vstep      = prod_v_rnd >>> 11;
  assign vsum       = {velocity_acc[39], velocity_acc} + {{2{vstep[38]}}, vstep};
  assign lo_rnd     = p_lo + 40'd524288;
  assign dsum       = {distance_acc[47], distance_acc} + {{8{p_hi[40]}}, p_hi}
                      + {29'd0, lo_rnd[39:20]};

  // Ring memories: written when a sample command is taken from the queue, read when any command is.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      sample_mem[write_slot] <= q_data.sample;
      delta_mem[write_slot]  <= q_data.delta;
    end
    if (q_pop) begin
      rd_sample <= sample_mem[write_slot];
      rd_delta  <= delta_mem[central];
    end
  end

  // Sequencer with the arithmetic registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      ring_vld     <= '0;
      write_slot   <= '0;
      sample_sum   <= '0;
      velocity_acc <= '0;
      distance_acc <= '0;
      out_valid    <= 1'b0;
    end else begin
      // The emit state reloads the result register itself.
      if (results.ready && (state != S_EMIT)) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (q_pop) begin
            cmd         <= q_data;
            hit         <= 1'b0;
            vld_old     <= ring_vld[write_slot];
            vld_central <= ring_vld[central];
            if (mem_we) begin
              ring_vld[write_slot] <= 1'b1;
            end
            state <= S_SUM;
          end
        end
        S_SUM: begin
          sample_sum <= sum_next;
          mag        <= sum_next[SUM_W-1] ? MAG_W'(-sum_next) : MAG_W'(sum_next);
          neg        <= sum_next[SUM_W-1];
          dt         <= vld_central ? rd_delta : '0;
          case (cmd.opcode)
            OP_SAMPLE: begin
              write_slot <= (write_slot == SLOT_W'(RING_DEPTH - 1)) ? '0
                                                                    : write_slot + 1'b1;
            end
            OP_RST_VEL: begin
              velocity_acc <= '0;
            end
            OP_RST_DIST: begin
              velocity_acc <= '0;
              distance_acc <= '0;
            end
            default: begin
              velocity_acc <= '0;
              distance_acc <= '0;
              ring_vld     <= '0;
              write_slot   <= '0;
            end
          endcase
          state <= S_DIV;
        end
        S_DIV: begin
          prod_q <= PROD_W'(mag) * PROD_W'(DIV_K);
          state  <= S_AVG;
        end
        S_AVG: begin
          // Deadband: a magnitude below the threshold reads as zero.
          if (quot < {5'd0, deadband}) begin
            avg <= '0;
          end else if (neg) begin
            avg <= -$signed({1'b0, quot});
          end else begin
            avg <= $signed({1'b0, quot});
          end
          state <= (cmd.opcode == OP_SAMPLE) ? S_VMUL : S_EMIT;
        end
        S_VMUL: begin
          prod_v <= avg * $signed({1'b0, dt});
          state  <= S_VACC;
        end
        S_VACC: begin
          if (vsum[40] != vsum[39]) begin
            velocity_acc <= vsum[40] ? VEL_MIN : VEL_MAX;
            hit          <= 1'b1;
          end else begin
            velocity_acc <= vsum[39:0];
          end
          state <= S_DLO;
        end
        S_DLO: begin
          // Velocity times delta is split at bit 20 into two partial products.
          p_lo  <= velocity_acc[19:0] * dt;
          state <= S_DHI;
        end
        S_DHI: begin
          p_hi  <= $signed(velocity_acc[39:20]) * $signed({1'b0, dt});
          state <= S_DACC;
        end
        S_DACC: begin
          if (dsum[48] != dsum[47]) begin
            distance_acc <= dsum[48] ? DIST_MIN : DIST_MAX;
            hit          <= 1'b1;
          end else begin
            distance_acc <= dsum[47:0];
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!out_valid || results.ready) begin
            out_valid <= 1'b1;
            out_avg   <= avg[16:0];
            out_vel   <= velocity_acc;
            out_dist  <= distance_acc;
            out_sat   <= hit;
            state     <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign results.valid          = out_valid;
  assign results.smoothed_accel = out_avg;
  assign results.velocity       = out_vel;
  assign results.distance       = out_dist;
  assign results.saturated      = out_sat;

  assign out_mag = out_avg[16] ? (~out_avg + 17'd1) : out_avg;

  // A clipped result sits on one of the limits.
  a_sat_at_limit: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_sat) |-> (out_vel == VEL_MAX || out_vel == VEL_MIN ||
                                out_dist == DIST_MAX || out_dist == DIST_MIN))
    else $error("saturated result not at a limit");

  // A non-zero smoothed value never lies inside the deadband.
  a_deadband: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_avg == '0 || out_mag >= {5'd0, deadband}))
    else $error("smoothed value inside the deadband");

  // The write slot stays within the ring.
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    (32'(write_slot) < RING_DEPTH))
    else $error("write slot beyond the ring");

endmodule

`default_nettype wire

// ===== rtl/accel_dead_reckoning_integrator_top.sv =====
// Top level of the single-axis accelerometer dead-reckoning integrator.
//
// Usage: input transactions arrive on the items channel (opcode, accel_raw,
// time_stamp) and every one of them yields exactly one transaction on the
// results channel (smoothed_accel, velocity, distance, saturated), in order.
// The gravity offset (index 0) and the deadband (index 1) are written on the
// plain write port cfg_we / cfg_index / cfg_data; the user is to write them
// only while the block is idle, which the block itself does not enforce.
// The back sequencer handles one command at a time: a sample passes through
// the states SUM, DIV, AVG, VMUL, VACC, DLO, DHI, DACC and EMIT, and a reset
// opcode goes from AVG straight to EMIT; this sets the sustained rate. The
// two-entry command queue lets further items be accepted while it is busy.
// Reset (rst, synchronous) clears the rings, the accumulators, the time
// reference and the queue, and loads the configuration reset values.
// When the receiver stalls, the finished result waits in the output
// register; the sequencer completes the next item and holds it until the
// register frees, while the queue fills and items.ready drops.
`timescale 1ns / 1ps
`default_nettype none

module accel_dead_reckoning_integrator_top import adri_pkg::*; #(
  parameter int RING_DEPTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic             cfg_index,
  input  wire logic [CFG_W-1:0] cfg_data,
  adri_in_if.sink               items,
  adri_out_if.source            results
);

  logic signed [15:0] gravity_offset;
  logic [11:0]        deadband;
  logic               q_push;
  logic               q_full;
  logic               q_pop;
  logic               q_empty;
  cmd_t               q_in;
  cmd_t               q_out;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      gravity_offset <= GRAVITY_RESET;
      deadband       <= DEADBAND_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_GRAVITY:  gravity_offset <= cfg_data[15:0];
        CFG_DEADBAND: deadband       <= cfg_data[11:0];
        default:      deadband       <= deadband;
      endcase
    end
  end

  adri_front u_front (
    .clk            (clk),
    .rst            (rst),
    .items          (items),
    .gravity_offset (gravity_offset),
    .q_full         (q_full),
    .q_push         (q_push),
    .q_data         (q_in)
  );

  adri_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

  adri_back #(
    .RING_DEPTH (RING_DEPTH)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .deadband (deadband),
    .q_empty  (q_empty),
    .q_data   (q_out),
    .q_pop    (q_pop),
    .results  (results)
  );

endmodule

`default_nettype wire
